### rtl/core/assert_macros.svh
// Assertion macros for the RTL in this folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/hgnp_pkg.sv
// Constants, types and point table builder for the hex grid nearest point block.
// No dependencies.
package hgnp_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int NUM_POINTS = 37;
	localparam int NUM_ROWS   = 7;
	localparam int ROW_LEN [NUM_ROWS] = '{4, 5, 6, 7, 6, 5, 4};

	// sqrt(3)/2 scaled by 2^30
	localparam longint ROOT3_HALF_Q30 = 64'd929887697;

	localparam int Q_W    = 16;                   // query field width
	localparam int IDX_W  = $clog2(NUM_POINTS);   // point index width
	localparam int PT_W   = FRAC_BITS + 3;        // |coordinate| < 4
	localparam int DIFF_W = Q_W + 1;              // point minus query
	localparam int SQ_W   = 2 * DIFF_W - 2;       // |diff| < 2^16
	localparam int DIST_W = SQ_W + 1;

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
	} pt_t;

	typedef pt_t [NUM_POINTS-1:0] pt_tab_t;

	// Build the layout: x centered per row in half units, y rounded away from zero.
	function automatic pt_tab_t build_pt_tab();
		pt_tab_t tab;
		int idx;
		int k;
		longint mag;
		longint m;
		longint halves;
		tab = '0;
		idx = 0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			k   = 3 - r;
			mag = (k < 0) ? longint'(-k) : longint'(k);
			m   = (mag * ROOT3_HALF_Q30 + (longint'(1) << (29 - FRAC_BITS)))
				>>> (30 - FRAC_BITS);
			if (k < 0) begin
				m = -m;
			end
			for (int j = 0; j < ROW_LEN[r]; j++) begin
				halves       = longint'(2 * j - (ROW_LEN[r] - 1));
				tab[idx].x   = PT_W'(halves * (longint'(1) << (FRAC_BITS - 1)));
				tab[idx].y   = PT_W'(m);
				idx++;
			end
		end
		return tab;
	endfunction

endpackage

### rtl/core/hgnp_rom.sv
// Point coordinate memory: one layout point per address, registered read.
// Depends on hgnp_pkg.
module hgnp_rom (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [hgnp_pkg::IDX_W-1:0] rd_addr,
	output hgnp_pkg::pt_t             rd_data
);
	import hgnp_pkg::*;

	localparam pt_tab_t PT_MEM = build_pt_tab();

	pt_t rd_data_q;

	// Read one point per cycle while rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= PT_MEM[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/hex_grid_nearest_point.sv
// Top level of the hex grid nearest point block: scan controller, distance pipe, output register.
// Depends on hgnp_pkg, hgnp_rom and assert_macros.svh.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+----------------------
//  query   | query_valid  | query_ready  | query_x, query_y
//  result  | result_valid | result_ready | pixel_index
//
// One item is scanned with one point memory read per cycle, then goes through
// three pipe stages (difference, square, sum and compare) and the output
// register. A new item is taken while a result waits.
// Reset clears control state only; the point table is a constant memory.
// A stalled result holds the block in its hold state until the result is taken.
`include "assert_macros.svh"

module hex_grid_nearest_point (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             query_valid,
	output logic                             query_ready,
	input  logic signed [hgnp_pkg::Q_W-1:0]  query_x,
	input  logic signed [hgnp_pkg::Q_W-1:0]  query_y,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [hgnp_pkg::IDX_W-1:0]       pixel_index
);
	import hgnp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;

	logic signed [Q_W-1:0] qx_q;
	logic signed [Q_W-1:0] qy_q;
	logic [IDX_W-1:0]      cnt_q;
	logic                  issue;
	pt_t                   rom_data;

	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]       sqx_s3, sqy_s3;
	logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

	logic [DIST_W-1:0]     dist_sum;
	logic                  take;
	logic [DIST_W-1:0]     best_d_q;
	logic [IDX_W-1:0]      best_idx_q;

	logic                  result_valid_q;
	logic [IDX_W-1:0]      pixel_index_q;
	logic                  out_free;
	logic                  fin;

	assign query_ready = (state_q == ST_IDLE);
	assign issue       = (state_q == ST_SCAN) && (cnt_q != IDX_W'(NUM_POINTS));
	assign out_free    = !result_valid_q || result_ready;
	assign fin         = v_s3 && last_s3;

	// Point memory
	hgnp_rom u_rom (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (cnt_q),
		.rd_data (rom_data)
	);

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (query_valid) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (fin) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the query on accept
	always_ff @(posedge clk) begin
		if (query_valid && query_ready) begin
			qx_q <= query_x;
			qy_q <= query_y;
		end
	end

	// Advance stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Difference and square stages
	assign sqx_full = dx_s2 * dx_s2;
	assign sqy_full = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		last_s1 <= (cnt_q == IDX_W'(NUM_POINTS - 1));
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		dx_s2   <= {{(DIFF_W-PT_W){rom_data.x[PT_W-1]}}, rom_data.x}
			- {qx_q[Q_W-1], qx_q};
		dy_s2   <= {{(DIFF_W-PT_W){rom_data.y[PT_W-1]}}, rom_data.y}
			- {qy_q[Q_W-1], qy_q};
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		sqx_s3  <= sqx_full[SQ_W-1:0];
		sqy_s3  <= sqy_full[SQ_W-1:0];
	end

	// Sum and compare; lower index wins a tie
	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign take     = (idx_s3 == '0) || (dist_sum < best_d_q);

	always_ff @(posedge clk) begin
		if (v_s3 && take) begin
			best_d_q   <= dist_sum;
			best_idx_q <= idx_s3;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			pixel_index_q <= best_idx_q;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_index  = pixel_index_q;

	// Checks
	`ASSERT_ALWAYS(a_idx_range, clk, arst_n,
		!result_valid || (pixel_index < IDX_W'(NUM_POINTS)))
	`ASSERT_ALWAYS(a_idle_empty, clk, arst_n,
		!query_ready || (!v_s1 && !v_s2 && !v_s3))
	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= IDX_W'(NUM_POINTS))
	`ASSERT_NEXT(a_fin_hold, clk, arst_n, fin, state_q == ST_HOLD)

endmodule

### test/hex_grid_nearest_point_test.sv
// Testbench for hex_grid_nearest_point: directed and random queries go through valid/ready,
// and each pixel_index is checked against a nearest-point search over the same hex layout.
// Depends on hgnp_pkg and the hex_grid_nearest_point RTL.
module hex_grid_nearest_point_test;
	import hgnp_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_QUERIES  = 1530;
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_AFTER      = 200;
	localparam int DRAIN_CYCLES    = 60;
	localparam longint NEIGHBOR_SQ = 300 * 300;

	typedef struct packed {
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
	} query_t;

	typedef struct {
		logic [IDX_W-1:0]      pixel;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
	} pixel_expect_t;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CADENCE} ready_mode_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  query_valid  = 1'b0;
	logic                  query_ready;
	logic signed [Q_W-1:0] query_x      = '0;
	logic signed [Q_W-1:0] query_y      = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [IDX_W-1:0]      pixel_index;

	longint        layout_x [NUM_POINTS];
	longint        layout_y [NUM_POINTS];
	query_t        pending_queries [$];
	pixel_expect_t expected_pixels [$];

	logic        query_taken = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          pattern_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          queries_taken = 0;
	int          results_checked = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          directed_count = 0;
	int          total_queries = 0;

	hex_grid_nearest_point dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query_x      (query_x),
		.query_y      (query_y),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_index  (pixel_index)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Scan the layout in index order; keep the first point with the smallest squared distance.
	function automatic logic [IDX_W-1:0] nearest_pixel(logic signed [Q_W-1:0] qx,
			logic signed [Q_W-1:0] qy);
		longint dx;
		longint dy;
		longint d;
		longint best_d;
		logic [IDX_W-1:0] best;
		best   = '0;
		best_d = 0;
		for (int i = 0; i < NUM_POINTS; i++) begin
			dx = layout_x[i] - longint'(qx);
			dy = layout_y[i] - longint'(qy);
			d  = dx * dx + dy * dy;
			if (i == 0 || d < best_d) begin
				best_d = d;
				best   = IDX_W'(i);
			end
		end
		return best;
	endfunction

	task automatic add_query(longint x, longint y);
		query_t q;
		q.x = Q_W'(x);
		q.y = Q_W'(y);
		pending_queries.push_back(q);
	endtask

	// Offer queued items in bursts with random gaps; hold each item until it is taken.
	always @(negedge clk) begin : drive_queries
		logic   offer;
		query_t item;
		offer = query_valid;
		if (arst_n && (!query_valid || query_taken)) begin
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_queries.size() != 0) begin
				item    = pending_queries.pop_front();
				query_x <= item.x;
				query_y <= item.y;
				offer   = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
				end
			end
		end
		query_valid <= offer;
	end

	// Stall results on a changing pattern; once, hold off long enough to back up the input.
	always @(negedge clk) begin : drain_results
		logic take;
		take = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && results_checked >= HOLD_AFTER) begin
				hold_left = HOLD_OFF_CYCLES - 1;
				hold_done = 1'b1;
			end else begin
				if (pattern_left == 0) begin
					ready_mode   = ready_mode_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(40, 300);
				end else begin
					pattern_left--;
				end
				case (ready_mode)
					READY_ALWAYS: begin
						take = 1'b1;
					end
					READY_COIN: begin
						take = ($urandom_range(0, 1) == 1);
					end
					READY_SPARSE: begin
						take = ($urandom_range(0, 4) == 0);
					end
					default: begin
						take = (pattern_left % 5) < 2;
					end
				endcase
			end
		end
		result_ready <= take;
	end

	// Predict on each accepted query, check each accepted result, and watch for a hang.
	always @(posedge clk or negedge arst_n) begin : check_pixels
		pixel_expect_t want;
		logic          moved;
		if (!arst_n) begin
			query_taken <= 1'b0;
			idle_cycles = 0;
		end else begin
			moved = 1'b0;
			query_taken <= query_valid && query_ready;
			if (query_valid && query_ready) begin
				want.pixel = nearest_pixel(query_x, query_y);
				want.x     = query_x;
				want.y     = query_y;
				expected_pixels.push_back(want);
				queries_taken++;
				moved = 1'b1;
			end
			if (result_valid && result_ready) begin
				moved = 1'b1;
				if (expected_pixels.size() == 0) begin
					$display("%0t: result with no query outstanding, expected none, got %0d",
						$time, pixel_index);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_index !== want.pixel) begin
						$display("%0t: pixel_index for query (%0d, %0d): expected %0d, got %0d",
							$time, want.x, want.y, want.pixel, pixel_index);
						mismatches++;
					end
					results_checked++;
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, idle_cycles, expected_pixels.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Build the layout, queue all queries, release reset, then wait for the last result.
	initial begin : run_queries
		int     idx;
		int     k;
		int     a;
		int     b;
		int     sel;
		longint row_y;
		longint ddx;
		longint ddy;

		// Rows of 4..7..4 points; x in half pitches, y rounded away from zero.
		idx = 0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			k     = 3 - r;
			row_y = (longint'(k < 0 ? -k : k) * ROOT3_HALF_Q30
				+ (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			if (k < 0) begin
				row_y = -row_y;
			end
			for (int j = 0; j < ROW_LEN[r]; j++) begin
				layout_x[idx] = longint'(2 * j - (ROW_LEN[r] - 1)) * (longint'(1) << (FRAC_BITS - 1));
				layout_y[idx] = row_y;
				idx++;
			end
		end

		// Directed: center, field extremes, alternating bits, corner points, ties.
		add_query(0, 0);
		add_query(-32768, -32768);
		add_query(-32768, 32767);
		add_query(32767, -32768);
		add_query(32767, 32767);
		add_query(0, 32767);
		add_query(0, -32768);
		add_query(32767, 0);
		add_query(-32768, 0);
		add_query(21845, -21846);
		add_query(-21846, 21845);
		add_query(1, -1);
		add_query(-1, 1);
		add_query(layout_x[0], layout_y[0]);
		add_query(layout_x[NUM_POINTS - 1], layout_y[NUM_POINTS - 1]);
		add_query(layout_x[0] - 1000, layout_y[0] + 1000);
		// equal distance within a row, across rows, and where the rounded y shifts the border
		add_query((layout_x[0] + layout_x[1]) / 2, layout_y[0]);
		add_query((layout_x[18] + layout_x[19]) / 2, layout_y[18]);
		add_query((layout_x[12] + layout_x[18]) / 2, (layout_y[12] + layout_y[18]) / 2);
		add_query((layout_x[0] + layout_x[4]) / 2, (layout_y[0] + layout_y[4]) / 2);
		add_query((layout_x[0] + layout_x[4]) / 2, (layout_y[0] + layout_y[4]) / 2 + 1);
		add_query((layout_x[4] + layout_x[9]) / 2, 332);
		add_query((layout_x[4] + layout_x[9]) / 2, 333);
		directed_count = pending_queries.size();

		// Random: mostly near the layout and on borders, some anywhere in the field.
		for (int n = 0; n < RANDOM_QUERIES; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				add_query(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
			end else if (sel < 75) begin
				a = $urandom_range(0, NUM_POINTS - 1);
				do begin
					b   = $urandom_range(0, NUM_POINTS - 1);
					ddx = layout_x[a] - layout_x[b];
					ddy = layout_y[a] - layout_y[b];
				end while (b == a || ddx * ddx + ddy * ddy > NEIGHBOR_SQ);
				add_query((layout_x[a] + layout_x[b]) / 2 + int'($urandom_range(0, 2)) - 1,
					(layout_y[a] + layout_y[b]) / 2 + int'($urandom_range(0, 2)) - 1);
			end else if (sel < 90) begin
				add_query($urandom_range(0, 65535), $urandom_range(0, 65535));
			end else begin
				a = $urandom_range(0, NUM_POINTS - 1);
				add_query(layout_x[a] + int'($urandom_range(0, 4)) - 2,
					layout_y[a] + int'($urandom_range(0, 4)) - 2);
			end
		end
		total_queries = pending_queries.size();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		while (queries_taken < total_queries) @(negedge clk);
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d results for %0d queries: %0d directed (extremes, layout points, ties)",
			results_checked, queries_taken, directed_count);
		$display("and %0d random, with one %0d-cycle receiver hold-off; %0d mismatches",
			total_queries - directed_count, HOLD_OFF_CYCLES, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/hgnp_pkg.sv
rtl/core/hgnp_rom.sv
rtl/core/hex_grid_nearest_point.sv
test/hex_grid_nearest_point_test.sv
